[rtl/core/reeq_pkg.sv]
// Shared types and constants for the rotary encoder event queue.
`default_nettype none
package reeq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MS    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_ENABLE = CSR_INDEX_W'(1);

   localparam logic [15:0] FILTER_MS_RESET    = 16'd20;
   localparam logic        QUEUE_ENABLE_RESET = 1'b1;

   localparam logic [1:0] OP_EDGE  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_CW   = 2'd1;
   localparam logic [1:0] DIR_CCW  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic        phase_a_level;
      logic        phase_b_level;
      logic [31:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] direction;
      logic       edge_accepted;
      logic       overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

[rtl/core/reeq_if.sv]
// Valid/ready channel interfaces for requests, responses and register writes.
`default_nettype none
interface reeq_req_if;
   import reeq_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface reeq_rsp_if;
   import reeq_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface reeq_csr_if;
   import reeq_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/reeq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module reeq_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/core/rotary_encoder_event_queue_core.sv]
// Rotary encoder direction decoder with a ring of queued direction events.
//
//   channel   dir   payload                                            accepted at
//   req_chan  in    operation, phase_a_level, phase_b_level, time_ms   valid & ready
//   rsp_chan  out   direction, edge_accepted, overflow                 valid & ready
//   csr_chan  in    index, data (filter_ms, queue_enable)              valid & ready
//
// For each item, the transfer cycle addresses the event RAM at the read pointer;
// the execute state then uses the registered read data and commits.
// The commit waits while the response register is full and not taken; a new
// request is still taken while a finished response waits.
// Synchronous reset clears pointers, last edge time, rsp valid; sets CSR defaults.
// Payload regs and the event RAM are not cleared. Register writes are always taken.
`default_nettype none
module rotary_encoder_event_queue_core #(
   parameter int QUEUE_DEPTH = reeq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   reeq_req_if.sink   req_chan,
   reeq_rsp_if.source rsp_chan,
   reeq_csr_if.sink   csr_chan
);
   import reeq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   state_type       state_ff, state_in;
   req_payload_type item_ff;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [31:0]     last_time_ff, last_time_in;
   logic [15:0]     filter_ms_ff;
   logic            queue_enable_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            req_xfer;
   logic            commit;
   logic            ram_we;
   logic [1:0]      ram_rd_data;
   logic [1:0]      edge_dir;
   logic [31:0]     elapsed;
   logic            pass;
   logic [IDX_W-1:0] wr_next;
   logic [IDX_W-1:0] rd_next;
   logic            full;
   logic            empty;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
   endfunction

   reeq_ram #(
      .WIDTH(2),
      .DEPTH(QUEUE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx_ff),
      .wr_data(edge_dir),
      .rd_addr(rd_idx_ff),
      .rd_data(ram_rd_data)
   );

   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign req_xfer         = req_chan.valid & req_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_chan.ready = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_EXEC: commit = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            req_chan.ready = 1'b0;
            commit         = 1'b0;
         end
      endcase
   end

   // Item datapath
   always_comb begin
      elapsed  = item_ff.time_ms - last_time_ff;
      pass     = elapsed > {16'd0, filter_ms_ff};
      edge_dir = (item_ff.phase_a_level == item_ff.phase_b_level) ? DIR_CW : DIR_CCW;
      wr_next  = advance(wr_idx_ff);
      rd_next  = advance(rd_idx_ff);
      full     = wr_next == rd_idx_ff;
      empty    = rd_idx_ff == wr_idx_ff;

      ram_we       = 1'b0;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      last_time_in = last_time_ff;
      rsp_data_in  = '0;

      case (item_ff.operation)
         OP_EDGE: begin
            if (pass) begin
               last_time_in              = item_ff.time_ms;
               rsp_data_in.edge_accepted = 1'b1;
               rsp_data_in.direction     = edge_dir;
               if (queue_enable_ff) begin
                  if (full) begin
                     rsp_data_in.overflow = 1'b1;
                  end else begin
                     ram_we    = commit;
                     wr_idx_in = wr_next;
                  end
               end
            end
         end
         OP_POP: begin
            if (!empty) begin
               rsp_data_in.direction = ram_rd_data;
               rd_idx_in             = rd_next;
            end
         end
         OP_CLEAR: rd_idx_in = wr_idx_ff;
         default: rsp_data_in = '0;
      endcase

      rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rd_idx_ff       <= '0;
         wr_idx_ff       <= '0;
         last_time_ff    <= '0;
         filter_ms_ff    <= FILTER_MS_RESET;
         queue_enable_ff <= QUEUE_ENABLE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            rd_idx_ff    <= rd_idx_in;
            wr_idx_ff    <= wr_idx_in;
            last_time_ff <= last_time_in;
         end
         if (csr_chan.valid) begin
            case (csr_chan.payload.index)
               CSR_FILTER_MS:    filter_ms_ff    <= csr_chan.payload.data;
               CSR_QUEUE_ENABLE: queue_enable_ff <= csr_chan.payload.data[0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_xfer) item_ff <= req_chan.payload;
      if (commit) rsp_data_ff <= rsp_data_in;
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (wr_next != rd_idx_ff))
      else $error("event written into a full ring");

   a_overflow_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.overflow) |-> rsp_data_ff.edge_accepted)
      else $error("overflow flagged without an accepted edge");

   a_pop_returns_event: assert property (@(posedge clock) disable iff (reset)
      (commit && item_ff.operation == OP_POP && !empty)
         |=> (rsp_valid_ff && rsp_data_ff.direction != DIR_NONE))
      else $error("pop of a non-empty ring returned no direction");

   a_transfer_starts_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

endmodule
`default_nettype wire
